// ----- src/tft_pkg.sv -----
// package for the flow table core: status codes, operation codes, controller states
// no dependencies
package tft_pkg;

   localparam int TableDepthDefault = 64;
   localparam logic [9:0] PrioLimit = 10'd1000;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_UNCHANGED = 4'd0,
      ST_PRIO_UPD  = 4'd1,
      ST_ADDED     = 4'd2,
      ST_FULL      = 4'd3,
      ST_REMOVED   = 4'd4,
      ST_NOT_FOUND = 4'd5,
      ST_HIT       = 4'd6,
      ST_MISS      = 4'd7,
      ST_QUERY     = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_WAIT,
      FSM_SHIFT,
      FSM_DONE
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, clear scan state
      logic rd;         // issue read at scan index
      logic eval;       // evaluate read data
      logic shift;      // shift phase: read index, write index-1
      logic finish;     // produce result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;  // last address issued
      logic stop;       // add or remove matched, scan can stop
      logic do_shift;   // remove needs gap closing
      logic shift_last;
   } sts_type;

endpackage

// ----- src/tft_ctrl.sv -----
// controller state machine for the flow table core
// depends on tft_pkg
module tft_ctrl
   import tft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    empty,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (start) state_in = empty ? FSM_DONE : FSM_SCAN;
         FSM_SCAN: if (sts.stop) state_in = FSM_WAIT;
                   else if (sts.scan_last) state_in = FSM_WAIT;
         FSM_WAIT: if (sts.do_shift) state_in = FSM_SHIFT;
                   else state_in = FSM_DONE;
         FSM_SHIFT: if (sts.shift_last) state_in = FSM_DONE;
         FSM_DONE: state_in = FSM_IDLE;
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         FSM_SCAN: begin
            cmd.rd = !sts.stop;
            cmd.eval = 1'b1;
         end
         FSM_WAIT: cmd.eval = 1'b1;
         FSM_SHIFT: cmd.shift = 1'b1;
         FSM_DONE: cmd.finish = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- src/tft_dpath.sv -----
// datapath of the flow table core: entry memory, scan compare, result registers
// depends on tft_pkg
module tft_dpath
   import tft_pkg::*;
#(
   parameter int TableDepth = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        empty,
   input  logic [14:0] csr_slotframe_size,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_flow_id,
   input  logic [7:0]  req_sf_handle,
   input  logic [15:0] req_slot,
   input  logic [7:0]  req_channel_offset,
   input  logic [9:0]  req_priority_req,
   input  logic        req_schedule_locked,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_found_flow_id,
   output logic [6:0]  rsp_entry_count,
   output logic [14:0] rsp_first_slot,
   output logic        rsp_has_cells
);

   localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int CW = $clog2(TableDepth + 1);
   localparam int EW = 58;

   logic [EW-1:0] mem [TableDepth];
   logic [EW-1:0] rdata_ff;

   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] addr_ff, addr_in;     // next address to read
   logic [CW-1:0] eidx_ff, eidx_in;     // index of data in rdata_ff
   logic          rvalid_ff, rvalid_in;
   logic [CW-1:0] hit_ff, hit_in;       // matched index for add or remove
   logic          found_ff, found_in;

   op_type        op_ff;
   logic [15:0]   fid_ff;
   logic [7:0]    sfh_ff, ch_ff;
   logic [15:0]   slot_ff;
   logic [9:0]    prio_ff;
   logic          lock_ff;

   logic [9:0]    best_ff, best_in;
   logic [15:0]   bflow_ff, bflow_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [14:0]   min_ff, min_in;
   logic          cells_ff, cells_in;
   logic          same_prio_ff, same_prio_in;

   logic          strobe_ff;
   logic [3:0]    status_ff, status_in;
   logic [15:0]   oflow_ff;
   logic [6:0]    ocnt_ff;
   logic [14:0]   ofirst_ff;
   logic          ocells_ff;

   logic [15:0] e_flow, e_slot;
   logic [7:0]  e_handle, e_ch;
   logic [9:0]  e_prio;
   logic        key4, key5, ev;

   assign {e_flow, e_handle, e_slot, e_ch, e_prio} = rdata_ff;
   assign key4 = e_flow == fid_ff && e_handle == sfh_ff && e_slot == slot_ff && e_ch == ch_ff;
   assign key5 = key4 && e_prio == prio_ff;
   assign ev = cmd.eval && rvalid_ff;
   assign empty = used_ff == '0;

   // memory: one write, one registered read
   logic          we;
   logic [AW-1:0] waddr;
   logic [EW-1:0] wdata;
   logic [AW-1:0] raddr;

   always_comb begin
      we = 1'b0;
      waddr = hit_ff[AW-1:0];
      wdata = {fid_ff, sfh_ff, slot_ff, ch_ff, prio_ff};
      raddr = addr_ff[AW-1:0];
      if (cmd.shift && rvalid_ff) begin
         we = 1'b1;
         waddr = eidx_ff[AW-1:0] - 1'b1;
         wdata = rdata_ff;
      end else if (cmd.finish && op_ff == OP_ADD && !found_ff && used_ff < CW'(TableDepth)) begin
         we = 1'b1;
         waddr = used_ff[AW-1:0];
      end else if (cmd.finish && op_ff == OP_ADD && found_ff && !same_prio_ff) begin
         we = 1'b1;
         wdata = {fid_ff, sfh_ff, slot_ff, ch_ff, prio_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      addr_in = addr_ff;
      eidx_in = eidx_ff;
      rvalid_in = 1'b0;
      hit_in = hit_ff;
      found_in = found_ff;
      best_in = best_ff;
      bflow_in = bflow_ff;
      cnt_in = cnt_ff;
      min_in = min_ff;
      cells_in = cells_ff;
      same_prio_in = same_prio_ff;
      used_in = used_ff;
      if (cmd.load) begin
         addr_in = '0;
         found_in = 1'b0;
         best_in = PrioLimit;
         bflow_in = '0;
         cnt_in = '0;
         min_in = csr_slotframe_size;
         cells_in = 1'b0;
      end
      if (cmd.rd) begin
         addr_in = addr_ff + 1'b1;
         eidx_in = addr_ff;
         rvalid_in = 1'b1;
      end
      if (ev && !found_ff) begin
         case (op_ff)
            OP_ADD: if (key4) begin
               found_in = 1'b1;
               hit_in = eidx_ff;
               same_prio_in = e_prio == prio_ff;
            end
            OP_REMOVE: if (key5) begin
               found_in = 1'b1;
               hit_in = eidx_ff;
               addr_in = eidx_ff + 1'b1;
            end
            OP_LOOKUP: if (!lock_ff && e_handle == sfh_ff && e_slot == slot_ff
                           && e_prio < best_ff) begin
               best_in = e_prio;
               bflow_in = e_flow;
            end
            OP_QUERY: if (e_flow == fid_ff) begin
               if (cnt_ff != 7'd127) cnt_in = cnt_ff + 1'b1;
               if (!e_slot[15]) begin
                  if ({1'b0, e_slot[14:0]} < {1'b0, min_ff}) min_in = e_slot[14:0];
                  if (!lock_ff) cells_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (cmd.shift) begin
         if (addr_ff < used_ff) begin
            addr_in = addr_ff + 1'b1;
            eidx_in = addr_ff;
            rvalid_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         if (op_ff == OP_ADD && !found_ff && used_ff < CW'(TableDepth))
            used_in = used_ff + 1'b1;
         if (op_ff == OP_REMOVE && found_ff) used_in = used_ff - 1'b1;
      end
   end

   // stop: add or remove matched in this eval
   assign sts.stop = ev && !found_ff && ((op_ff == OP_ADD && key4) || (op_ff == OP_REMOVE && key5));
   assign sts.scan_last = cmd.rd && (addr_ff + 1'b1 == used_ff);
   assign sts.do_shift = op_ff == OP_REMOVE && found_ff;
   assign sts.shift_last = !rvalid_ff && addr_ff >= used_ff;

   always_comb begin
      status_in = ST_QUERY;
      case (op_ff)
         OP_ADD: status_in = found_ff ? (same_prio_ff ? ST_UNCHANGED : ST_PRIO_UPD)
                           : (used_ff < CW'(TableDepth) ? ST_ADDED : ST_FULL);
         OP_REMOVE: status_in = found_ff ? ST_REMOVED : ST_NOT_FOUND;
         OP_LOOKUP: status_in = (best_ff != PrioLimit) ? ST_HIT : ST_MISS;
         OP_QUERY: status_in = ST_QUERY;
         default: status_in = ST_QUERY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         strobe_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         strobe_ff <= cmd.finish;
         rvalid_ff <= rvalid_in;
      end
      addr_ff <= addr_in;
      eidx_ff <= eidx_in;
      hit_ff <= hit_in;
      found_ff <= found_in;
      best_ff <= best_in;
      bflow_ff <= bflow_in;
      cnt_ff <= cnt_in;
      min_ff <= min_in;
      cells_ff <= cells_in;
      same_prio_ff <= same_prio_in;
      if (cmd.load) begin
         op_ff <= op_type'(req_operation);
         fid_ff <= req_flow_id;
         sfh_ff <= req_sf_handle;
         slot_ff <= req_slot;
         ch_ff <= req_channel_offset;
         prio_ff <= req_priority_req;
         lock_ff <= req_schedule_locked;
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         oflow_ff <= (op_ff == OP_LOOKUP) ? bflow_ff : 16'd0;
         ocnt_ff <= (op_ff == OP_QUERY) ? cnt_ff : 7'd0;
         ofirst_ff <= (op_ff == OP_QUERY && min_ff != csr_slotframe_size) ? min_ff : 15'd0;
         ocells_ff <= (op_ff == OP_QUERY) ? cells_ff : 1'b0;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_found_flow_id = oflow_ff;
   assign rsp_entry_count = ocnt_ff;
   assign rsp_first_slot = ofirst_ff;
   assign rsp_has_cells = ocells_ff;

endmodule

// ----- src/tsch_flow_table_core.sv -----
// flow table core: one item at a time; a scan reads every used entry unless an add or
// remove matches early, an empty table skips the scan, and a remove that matches closes
// the gap by shifting the later entries down before the result; busy drops with the strobe, so the next
// beat is taken at the end of the strobe cycle; scan rate is one entry per cycle, set by the
// single read port of the entry memory
// reset: synchronous, clears the entry count and the controller; entries stay undefined;
// slotframe size returns to 1024. results are a one-cycle strobe, the receiver cannot stall
// depends on tft_pkg, tft_ctrl, tft_dpath
module tsch_flow_table_core
   import tft_pkg::*;
#(
   parameter int TableDepth = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_flow_id,
   input  logic [7:0]  req_sf_handle,
   input  logic [15:0] req_slot,
   input  logic [7:0]  req_channel_offset,
   input  logic [9:0]  req_priority_req,
   input  logic        req_schedule_locked,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_found_flow_id,
   output logic [6:0]  rsp_entry_count,
   output logic [14:0] rsp_first_slot,
   output logic        rsp_has_cells
);

   logic [14:0] sf_size_ff;
   cmd_type cmd;
   sts_type sts;
   logic empty;

   always_ff @(posedge clock) begin
      if (reset) sf_size_ff <= 15'd1024;
      else if (csr_we) sf_size_ff <= csr_wdata;
   end

   tft_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .empty(empty),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   tft_dpath #(.TableDepth(TableDepth)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .empty(empty),
      .csr_slotframe_size(sf_size_ff),
      .req_operation(req_operation), .req_flow_id(req_flow_id),
      .req_sf_handle(req_sf_handle), .req_slot(req_slot),
      .req_channel_offset(req_channel_offset), .req_priority_req(req_priority_req),
      .req_schedule_locked(req_schedule_locked),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_found_flow_id(rsp_found_flow_id), .rsp_entry_count(rsp_entry_count),
      .rsp_first_slot(rsp_first_slot), .rsp_has_cells(rsp_has_cells)
   );

endmodule

// ----- dv/tb_tsch_flow_table_core.sv -----
// testbench for tsch_flow_table_core: queued command driver, strobe monitor and a
// behavioral flow table predictor checked field by field against every response
// depends on tft_pkg and the tsch_flow_table_core rtl
`timescale 1ns / 100ps

module tb_tsch_flow_table_core;
   import tft_pkg::*;

   localparam int Depth = 64;
   localparam int CycleLimit = 600000;
   localparam int K_ITEM = 0;
   localparam int K_CFG = 1;
   localparam int K_PAUSE = 2;
   localparam int SettleCycles = Depth + 12;

   typedef struct {
      int          kind;
      op_type      op;
      logic [15:0] fid;
      logic [7:0]  sfh;
      logic [15:0] slot;
      logic [7:0]  ch;
      logic [9:0]  prio;
      logic        lck;
      logic [14:0] cfg;
      bit          calm;
   } beat_type;

   typedef struct {
      status_type  status;
      logic [15:0] found;
      logic [6:0]  count;
      logic [14:0] first;
      logic        cells;
   } resp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_flow_id = '0;
   logic [7:0]  req_sf_handle = '0;
   logic [15:0] req_slot = '0;
   logic [7:0]  req_channel_offset = '0;
   logic [9:0]  req_priority_req = '0;
   logic        req_schedule_locked = 1'b0;
   logic        csr_we = 1'b0;
   logic [14:0] csr_wdata = '0;
   logic        rsp_strobe;
   logic [3:0]  rsp_status;
   logic [15:0] rsp_found_flow_id;
   logic [6:0]  rsp_entry_count;
   logic [14:0] rsp_first_slot;
   logic        rsp_has_cells;

   beat_type pending_q[$];
   resp_type expected_q[$];
   beat_type burst_q[$];
   int    errors = 0;
   int    cycles = 0;
   int    quiet_cycles = 0;

   // flow table shadow
   logic [15:0] tbl_flow[Depth];
   logic [7:0]  tbl_handle[Depth];
   logic [15:0] tbl_slot[Depth];
   logic [7:0]  tbl_chan[Depth];
   logic [9:0]  tbl_prio[Depth];
   int          tbl_used = 0;
   logic [14:0] sf_size = 15'd1024;

   tsch_flow_table_core DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic resp_type table_update(beat_type b);
      resp_type r;
      int    hit_at;
      int    best;
      int    min_ts;
      r = '{ST_UNCHANGED, '0, '0, '0, 1'b0};
      hit_at = -1;
      case (b.op)
         OP_ADD: begin
            for (int i = 0; i < tbl_used; i++)
               if (hit_at < 0 && tbl_flow[i] == b.fid && tbl_handle[i] == b.sfh &&
                   tbl_slot[i] == b.slot && tbl_chan[i] == b.ch)
                  hit_at = i;
            if (hit_at >= 0) begin
               if (tbl_prio[hit_at] == b.prio) r.status = ST_UNCHANGED;
               else begin
                  tbl_prio[hit_at] = b.prio;
                  r.status = ST_PRIO_UPD;
               end
            end else if (tbl_used < Depth) begin
               tbl_flow[tbl_used] = b.fid;
               tbl_handle[tbl_used] = b.sfh;
               tbl_slot[tbl_used] = b.slot;
               tbl_chan[tbl_used] = b.ch;
               tbl_prio[tbl_used] = b.prio;
               tbl_used++;
               r.status = ST_ADDED;
            end else r.status = ST_FULL;
         end
         OP_REMOVE: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < tbl_used; i++)
               if (hit_at < 0 && tbl_flow[i] == b.fid && tbl_handle[i] == b.sfh &&
                   tbl_slot[i] == b.slot && tbl_chan[i] == b.ch && tbl_prio[i] == b.prio)
                  hit_at = i;
            if (hit_at >= 0) begin
               for (int k = hit_at; k + 1 < tbl_used; k++) begin
                  tbl_flow[k] = tbl_flow[k+1];
                  tbl_handle[k] = tbl_handle[k+1];
                  tbl_slot[k] = tbl_slot[k+1];
                  tbl_chan[k] = tbl_chan[k+1];
                  tbl_prio[k] = tbl_prio[k+1];
               end
               tbl_used--;
               r.status = ST_REMOVED;
            end
         end
         OP_LOOKUP: begin
            best = 1000;
            r.status = ST_MISS;
            if (!b.lck)
               for (int i = 0; i < tbl_used; i++)
                  if (tbl_handle[i] == b.sfh && tbl_slot[i] == b.slot &&
                      int'(tbl_prio[i]) < best) begin
                     best = tbl_prio[i];
                     r.found = tbl_flow[i];
                     r.status = ST_HIT;
                  end
         end
         default: begin
            min_ts = sf_size;
            for (int i = 0; i < tbl_used; i++)
               if (tbl_flow[i] == b.fid) begin
                  r.count++;
                  if (!tbl_slot[i][15]) begin
                     if (int'(tbl_slot[i]) < min_ts) min_ts = tbl_slot[i];
                     if (!b.lck) r.cells = 1'b1;
                  end
               end
            r.first = (min_ts == int'(sf_size)) ? 15'd0 : 15'(min_ts);
            r.status = ST_QUERY;
         end
      endcase
      return r;
   endfunction

   // drive side: one assignment per signal per edge
   always @(posedge clock) begin
      beat_type nxt;
      logic  start_n;
      logic  we_n;
      cycles <= cycles + 1;
      we_n = 1'b0;
      start_n = 1'b0;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_q.push_back(table_update(pending_q.pop_front()));
         end
         if (start && busy) start_n = 1'b1;
         else if (pending_q.size() > 0) begin
            nxt = pending_q[0];
            if (nxt.kind == K_ITEM) begin
               if (nxt.calm || $urandom_range(99) >= 22) begin
                  start_n = 1'b1;
                  req_operation <= nxt.op;
                  req_flow_id <= nxt.fid;
                  req_sf_handle <= nxt.sfh;
                  req_slot <= nxt.slot;
                  req_channel_offset <= nxt.ch;
                  req_priority_req <= nxt.prio;
                  req_schedule_locked <= nxt.lck;
               end
            end else if (!start && expected_q.size() == 0 && quiet_cycles >= SettleCycles) begin
               void'(pending_q.pop_front());
               if (nxt.kind == K_CFG) begin
                  we_n = 1'b1;
                  csr_wdata <= nxt.cfg;
                  sf_size = nxt.cfg;
               end
            end
         end
         start <= start_n;
         csr_we <= we_n;
      end
      quiet_cycles <= (start || expected_q.size() > 0) ? 0 : quiet_cycles + 1;
   end

   always @(posedge clock) begin
      resp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing expected, status %0d", $time, rsp_status);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_status != want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_found_flow_id != want.found) begin
               $display("%0t: found_flow_id exp %h got %h", $time, want.found,
                        rsp_found_flow_id);
               errors++;
            end
            if (rsp_entry_count != want.count) begin
               $display("%0t: entry_count exp %0d got %0d", $time, want.count,
                        rsp_entry_count);
               errors++;
            end
            if (rsp_first_slot != want.first) begin
               $display("%0t: first_slot exp %0d got %0d", $time, want.first,
                        rsp_first_slot);
               errors++;
            end
            if (rsp_has_cells != want.cells) begin
               $display("%0t: has_cells exp %0d got %0d", $time, want.cells, rsp_has_cells);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CycleLimit) begin
         $display("tsch_flow_table_core test failed");
         $finish;
      end
   end

   function automatic beat_type cmd(op_type op, logic [15:0] fid, logic [7:0] sfh,
                                    logic [15:0] slot, logic [7:0] ch, logic [9:0] prio,
                                    logic lck);
      beat_type b;
      b = '{K_ITEM, op, fid, sfh, slot, ch, prio, lck, '0, 1'b0};
      return b;
   endfunction

   // mostly small pools so adds, removes and lookups collide; some full-range beats
   function automatic beat_type rand_cmd(op_type op);
      beat_type b;
      if ($urandom_range(99) < 20)
         return cmd(op, 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                    10'($urandom), 1'($urandom));
      b = cmd(op, 16'($urandom_range(3)), 8'($urandom_range(2)), '0, 8'($urandom_range(1)),
              '0, $urandom_range(99) < 15);
      case ($urandom_range(6))
         0: b.slot = 16'hFFFF;
         1: b.slot = 16'h8000;
         2: b.slot = 16'd1024;
         3: b.slot = 16'd5;
         default: b.slot = 16'($urandom_range(3));
      endcase
      case ($urandom_range(5))
         0: b.prio = 10'd999;
         1: b.prio = 10'd1000;
         2: b.prio = 10'd1023;
         default: b.prio = 10'($urandom_range(3));
      endcase
      return b;
   endfunction

   function automatic beat_type rand_mix();
      int w;
      w = $urandom_range(99);
      return rand_cmd(w < 35 ? OP_ADD : w < 60 ? OP_REMOVE : w < 80 ? OP_LOOKUP : OP_QUERY);
   endfunction

   function automatic beat_type cfg_write(logic [14:0] v);
      beat_type b;
      b = cmd(OP_ADD, '0, '0, '0, '0, '0, 1'b0);
      b.kind = K_CFG;
      b.cfg = v;
      return b;
   endfunction

   initial begin
      beat_type b;
      int    pick;
      // directed: extremes, duplicates, priority update, ties, locks, negative slots
      pending_q.push_back(cmd(OP_QUERY, 16'hFFFF, '0, '0, '0, '0, 1'b0));
      pending_q.push_back(cmd(OP_LOOKUP, '0, '0, '0, '0, '0, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'hFFFF, 8'hFF, 16'h7FFF, 8'hFF, 10'h3FF, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'hFFFF, 8'hFF, 16'h7FFF, 8'hFF, 10'h3FF, 1'b1));
      pending_q.push_back(cmd(OP_ADD, 16'hFFFF, 8'hFF, 16'h7FFF, 8'hFF, 10'd3, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'hFFFF, 8'h01, 16'hFFFF, 8'h00, 10'd7, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'hFFFF, 8'h01, 16'h8000, 8'h00, 10'd7, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'h0000, 8'h00, 16'h0000, 8'h00, 10'd0, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'h1234, 8'h05, 16'd9, 8'h02, 10'd20, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'h4321, 8'h05, 16'd9, 8'h03, 10'd20, 1'b0));
      pending_q.push_back(cmd(OP_ADD, 16'h5555, 8'h06, 16'd9, 8'h03, 10'd1000, 1'b0));
      pending_q.push_back(cmd(OP_LOOKUP, '0, 8'h05, 16'd9, '0, '0, 1'b0));
      pending_q.push_back(cmd(OP_LOOKUP, '0, 8'h05, 16'd9, '0, '0, 1'b1));
      pending_q.push_back(cmd(OP_LOOKUP, '0, 8'h06, 16'd9, '0, '0, 1'b0));
      pending_q.push_back(cmd(OP_LOOKUP, '0, 8'hFF, 16'h7FFF, '0, '0, 1'b0));
      pending_q.push_back(cmd(OP_QUERY, 16'hFFFF, '0, '0, '0, '0, 1'b0));
      pending_q.push_back(cmd(OP_QUERY, 16'hFFFF, '0, '0, '0, '0, 1'b1));
      pending_q.push_back(cmd(OP_REMOVE, 16'hFFFF, 8'hFF, 16'h7FFF, 8'hFF, 10'd4, 1'b0));
      pending_q.push_back(cmd(OP_REMOVE, 16'hFFFF, 8'hFF, 16'h7FFF, 8'hFF, 10'd3, 1'b0));
      pending_q.push_back(cmd(OP_QUERY, 16'hFFFF, '0, '0, '0, '0, 1'b0));
      pending_q.push_back(cmd(OP_QUERY, 16'h0000, '0, '0, '0, '0, 1'b0));

      // fill past capacity, then drain the burst in random order among other traffic
      pending_q.push_back(cfg_write(15'h7FFF));
      for (int i = 0; i < 70; i++) begin
         b = rand_cmd(OP_ADD);
         if (i >= 60) b.calm = 1'b1;
         pending_q.push_back(b);
         burst_q.push_back(b);
      end
      pending_q.push_back(cmd(OP_QUERY, 16'h0001, '0, '0, '0, '0, 1'b0));
      while (burst_q.size() > 0) begin
         pick = $urandom_range(burst_q.size() - 1);
         b = burst_q[pick];
         burst_q.delete(pick);
         b.op = OP_REMOVE;
         pending_q.push_back(b);
         pending_q.push_back(rand_mix());
      end
      b.kind = K_PAUSE;
      pending_q.push_back(b);
      for (int i = 0; i < 80; i++) pending_q.push_back(rand_mix());
      pending_q.push_back(cfg_write(15'd1));
      for (int i = 0; i < 130; i++) begin
         b = rand_mix();
         b.calm = (i < 100);
         pending_q.push_back(b);
      end
      pending_q.push_back(cfg_write(15'd5));
      for (int i = 0; i < 130; i++) pending_q.push_back(rand_mix());
      pending_q.push_back(cfg_write(15'($urandom_range(1, 32767))));
      for (int i = 0; i < 130; i++) pending_q.push_back(rand_mix());

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && expected_q.size() == 0);
      repeat (SettleCycles * 2) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("tsch_flow_table_core test passed");
      else
         $display("tsch_flow_table_core test failed");
      $finish;
   end

endmodule
